FILE: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window maximum
// Default sizes, fixed field widths and the sequencer state type.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int MAX_WINDOW_DEF = 64;
	localparam int DATA_WIDTH_DEF = 32;

	// sample positions wrap at 16 bits; ages are taken modulo this width
	localparam int POS_WIDTH = 16;
	// width of the window size register
	localparam int WIN_WIDTH = 7;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_FRONT_RD  = 6'b000010,
		ST_FRONT_CHK = 6'b000100,
		ST_BACK_RD   = 6'b001000,
		ST_BACK_CHK  = 6'b010000,
		ST_PUSH      = 6'b100000
	} swm_state_t;

endpackage

FILE: rtl/swm_ram.sv
// ----------------------------------------------------------------------------
// swm_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module swm_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/sliding_window_maximum.sv
// ----------------------------------------------------------------------------
// sliding_window_maximum: running maximum over a window of signed samples
// Keeps a monotonic deque of (value, position) pairs in a ring RAM and
// walks it with a small sequencer, one RAM read and one compare per step.
// ----------------------------------------------------------------------------
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------
//  cfg      | cfg_valid / cfg_ready      | window_size
//  in       | in_valid / in_stall        | sample, sequence_start
//  out      | out_valid / out_stall      | window_max
//
//  A sample drops stale front entries through FRONT_RD and FRONT_CHK, pops
//  back entries it covers through BACK_RD and BACK_CHK, then writes in PUSH;
//  an empty deque goes straight to PUSH. Each deque step is a read state and
//  a check state, since the ring RAM registers its read data.
//  Reset clears head, entry count, fill count, position counter and the
//  window size (to 1); the ring RAM holds no reset value and needs none.
//  A result waits in the output register; the next sample is taken while it
//  waits, and the sequencer holds in its last step until the register frees.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module sliding_window_maximum
	import swm_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [WIN_WIDTH-1:0]         window_size,
	// sample input
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] sample,
	input  logic                         sequence_start,
	// result output
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] window_max
);

	// ring index width, count width (holds MAX_WINDOW itself)
	localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW  = $clog2(MAX_WINDOW + 1);
	localparam int SW  = ((AW > CW) ? AW : CW) + 1;
	localparam int KW  = ((CW > WIN_WIDTH) ? CW : WIN_WIDTH) + 1;
	localparam int RW  = DATA_WIDTH + POS_WIDTH;

	swm_state_t state_q, state_d;

	logic [WIN_WIDTH-1:0]         window_size_q;
	logic [AW-1:0]                head_q;
	logic [CW-1:0]                entry_count_q;
	logic [CW-1:0]                fill_count_q;
	logic [POS_WIDTH-1:0]         position_q;
	logic signed [DATA_WIDTH-1:0] sample_q;
	logic signed [DATA_WIDTH-1:0] front_q;
	logic                         out_valid_q;
	logic signed [DATA_WIDTH-1:0] window_max_q;

	logic [CW-1:0]                k_eff;
	logic [KW-1:0]                ws_ext;
	logic                         in_xfer;
	logic                         out_free;

	logic [AW-1:0]                rd_addr;
	logic [AW-1:0]                wr_addr;
	logic                         wr_en;
	logic [RW-1:0]                rd_data;
	logic signed [DATA_WIDTH-1:0] rd_value;
	logic [POS_WIDTH-1:0]         rd_pos;
	logic [POS_WIDTH-1:0]         age;
	logic                         too_old;
	logic                         back_covered;
	logic [CW-1:0]                fill_next;
	logic                         emit;

	// ring index: head plus offset, wrapped once at MAX_WINDOW
	function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
						    input logic [CW-1:0] offset);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(offset);
		if (sum >= SW'(MAX_WINDOW)) begin
			sum = sum - SW'(MAX_WINDOW);
		end
		return sum[AW-1:0];
	endfunction

	// clamp the window size into 1..MAX_WINDOW
	always_comb begin
		ws_ext = KW'(window_size_q);
		if (ws_ext == '0) begin
			k_eff = CW'(1);
		end else if (ws_ext > KW'(MAX_WINDOW)) begin
			k_eff = CW'(MAX_WINDOW);
		end else begin
			k_eff = ws_ext[CW-1:0];
		end
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign rd_value = rd_data[DATA_WIDTH-1:0];
	assign rd_pos   = rd_data[DATA_WIDTH +: POS_WIDTH];
	assign age      = position_q - rd_pos;
	assign too_old  = (age >= POS_WIDTH'(k_eff));
	assign back_covered = (rd_value <= sample_q);

	assign fill_next = (fill_count_q < k_eff) ? fill_count_q + CW'(1) : fill_count_q;
	assign emit      = (fill_next >= k_eff);

	// read front in the front steps, the last entry in the back steps
	always_comb begin
		case (state_q)
			ST_BACK_RD: rd_addr = ring_slot(head_q, entry_count_q - CW'(1));
			default:    rd_addr = head_q;
		endcase
	end

	assign wr_en   = (state_q == ST_PUSH) && out_free;
	assign wr_addr = ring_slot(head_q, entry_count_q);

	swm_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({position_q, sample_q}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer: drop stale fronts, pop backs not above the sample, then push
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_FRONT_RD;
			end
			ST_FRONT_RD: begin
				state_d = (entry_count_q == '0) ? ST_PUSH : ST_FRONT_CHK;
			end
			ST_FRONT_CHK: begin
				state_d = too_old ? ST_FRONT_RD : ST_BACK_RD;
			end
			ST_BACK_RD: begin
				state_d = (entry_count_q == '0) ? ST_PUSH : ST_BACK_CHK;
			end
			ST_BACK_CHK: begin
				state_d = back_covered ? ST_BACK_RD : ST_PUSH;
			end
			ST_PUSH: begin
				// hold until the output register can take the result
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= WIN_WIDTH'(1);
			head_q        <= '0;
			entry_count_q <= '0;
			fill_count_q  <= '0;
			position_q    <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				window_size_q <= window_size;
			end
			// load a new result as the push completes, else drop a taken one
			if (wr_en && emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					// a new sequence empties the deque and restarts the fill
					if (in_xfer && sequence_start) begin
						head_q        <= '0;
						entry_count_q <= '0;
						fill_count_q  <= '0;
					end
				end
				ST_FRONT_CHK: begin
					if (too_old) begin
						head_q        <= ring_slot(head_q, CW'(1));
						entry_count_q <= entry_count_q - CW'(1);
					end
				end
				ST_BACK_CHK: begin
					if (back_covered) begin
						entry_count_q <= entry_count_q - CW'(1);
					end
				end
				ST_PUSH: begin
					if (out_free) begin
						entry_count_q <= entry_count_q + CW'(1);
						fill_count_q  <= fill_next;
						position_q    <= position_q + POS_WIDTH'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= sample;
		end
		if (state_q == ST_FRONT_CHK && !too_old) begin
			front_q <= rd_value;
		end
		if (wr_en && emit) begin
			// with every older entry popped, the new sample is the front
			window_max_q <= (entry_count_q == '0) ? sample_q : front_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

	// deque occupancy never passes the ring depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(MAX_WINDOW))
		else $error("deque entry count beyond ring depth");

	// after the front drops, the deque holds fewer than a window of entries,
	// so a push never meets a full ring
	a_no_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUSH) |-> (entry_count_q < k_eff))
		else $error("push into a deque holding a full window");

	// an accepted sample starts the front walk on the next cycle
	a_accept_walk: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_FRONT_RD))
		else $error("accepted sample did not start the deque walk");

	// a new result appears only as the push step completes
	a_result_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_PUSH && out_free))
		else $error("result raised outside the push step");

	// fill count stays within the ring depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_count_q <= CW'(MAX_WINDOW))
		else $error("fill count beyond ring depth");

endmodule

FILE: tb/sv/sliding_window_maximum_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_maximum_tb: self-checking bench for the sliding window maximum
// Sends sample transfers with random gaps against random result stalls. A
// behavioral monotonic deque in the bench predicts every window maximum, and
// each result transfer is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module sliding_window_maximum_tb;
	import swm_pkg::*;

	localparam int MAX_W = MAX_WINDOW_DEF;
	localparam int DW = DATA_WIDTH_DEF;
	// worst case for a sample with no result: every entry dropped or popped
	localparam int SETTLE_CYCLES = 4 * MAX_W + 16;
	localparam int CYCLE_LIMIT = 3_000_000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 62;
	// ring of pending predictions; only a few are ever outstanding
	localparam int EXPECT_DEPTH = 16;
	localparam logic signed [DW-1:0] SAMPLE_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic signed [DW-1:0] SAMPLE_MAX = {1'b0, {(DW-1){1'b1}}};

	typedef enum int {
		RUN_NOISE,
		RUN_NARROW,
		RUN_FALLING,
		RUN_RISING,
		RUN_EXTREME
	} run_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [WIN_WIDTH-1:0]  window_size = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic signed [DW-1:0]  sample = '0;
	logic                  sequence_start = 1'b0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [DW-1:0]  window_max;

	// Bench copy of the deque: ring of (value, position), values falling
	// from front to back.
	logic signed [DW-1:0]  chain_value [MAX_W];
	logic [POS_WIDTH-1:0]  chain_pos [MAX_W];
	int                    chain_head = 0;
	int                    chain_len = 0;
	logic [POS_WIDTH-1:0]  next_pos = '0;
	int                    run_fill = 0;
	logic [WIN_WIDTH-1:0]  window_setting = 1;

	// predicted window maxima, oldest at expect_rd
	logic signed [DW-1:0]  expected_max [EXPECT_DEPTH];
	int                    expect_wr = 0;
	int                    expect_rd = 0;

	int                    fail_count = 0;
	int                    cycle_count = 0;
	int                    stall_hold = 0;
	// set for stretches with no gaps on either side
	bit                    steady = 1'b0;

	sliding_window_maximum dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.window_size    (window_size),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sample         (sample),
		.sequence_start (sequence_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.window_max     (window_max)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Zero reads as one; anything above the deque depth is held at the depth.
	function automatic int window_span(input logic [WIN_WIDTH-1:0] w);
		if (w == 0)
			return 1;
		if (w > MAX_W)
			return MAX_W;
		return int'(w);
	endfunction

	// Advance the bench deque by one accepted sample and queue the maximum
	// once the current sequence has filled the window.
	function automatic void track_sample(input logic signed [DW-1:0] s, input logic start);
		int span;
		span = window_span(window_setting);
		// a sequence start empties the deque; the position counter keeps running
		if (start) begin
			chain_head = 0;
			chain_len = 0;
			run_fill = 0;
		end
		// drop front entries a full window old; ages wrap at the position width
		while (chain_len > 0 && POS_WIDTH'(next_pos - chain_pos[chain_head]) >= span) begin
			chain_head = (chain_head + 1) % MAX_W;
			chain_len--;
		end
		// pop back entries that the new sample covers, equal values included
		while (chain_len > 0 && chain_value[(chain_head + chain_len - 1) % MAX_W] <= s)
			chain_len--;
		if (chain_len >= MAX_W) begin
			chain_head = (chain_head + 1) % MAX_W;
			chain_len--;
		end
		chain_value[(chain_head + chain_len) % MAX_W] = s;
		chain_pos[(chain_head + chain_len) % MAX_W] = next_pos;
		chain_len++;
		next_pos++;
		if (run_fill < span)
			run_fill++;
		if (run_fill >= span) begin
			expected_max[expect_wr % EXPECT_DEPTH] = chain_value[chain_head];
			expect_wr++;
		end
	endfunction

	// Gap before a sample transfer: mostly none or short, now and then long.
	function automatic int idle_length();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Drive one sample, hold it through stalls, and predict once it transfers.
	// Valid stays high on return so back-to-back samples need no dip.
	task automatic send_sample(input logic signed [DW-1:0] s, input logic start);
		int gap;
		gap = idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		sequence_start <= start;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		track_sample(s, start);
	endtask

	// Hold the input until every predicted maximum has come back.
	task automatic wait_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expect_wr != expect_rd);
	endtask

	// Drain, then let a sample that produces no result finish in the block.
	task automatic settle();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the window size while the block is idle.
	task automatic write_window(input logic [WIN_WIDTH-1:0] w);
		settle();
		cfg_valid <= 1'b1;
		window_size <= w;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		window_setting = w;
	endtask

	// One sequence of samples in a random shape; a rare stray start breaks it.
	task automatic send_run(input int len, input logic opener);
		run_style_t style;
		logic signed [DW-1:0] v;
		style = run_style_t'($urandom_range(RUN_NOISE, RUN_EXTREME));
		v = $urandom;
		for (int i = 0; i < len; i++) begin
			case (style)
				RUN_NOISE: begin
					v = $urandom;
				end
				RUN_NARROW: begin
					// tight range: many equal values and back pops
					v = $urandom_range(0, 6);
					v = v - 3;
				end
				RUN_FALLING: begin
					// long deques and front drops by age
					v = v - $urandom_range(0, 255);
				end
				RUN_RISING: begin
					v = v + $urandom_range(0, 255);
				end
				default: begin
					case ($urandom_range(0, 3))
						0: v = SAMPLE_MIN;
						1: v = SAMPLE_MAX;
						2: v = '0;
						default: v = '1;
					endcase
				end
			endcase
			send_sample(v, (i == 0) ? opener : ($urandom_range(0, 59) == 0));
		end
	endtask

	// After reset the window is one: each sample comes straight back.
	task automatic test_default_window();
		send_sample(SAMPLE_MIN, 1'b1);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample('0, 1'b0);
		send_sample('1, 1'b0);
		send_sample(1, 1'b0);
		send_sample({(DW/2){2'b01}}, 1'b0);
		send_sample({(DW/2){2'b10}}, 1'b0);
	endtask

	// Window of four: back pops on larger and equal values, front drop by
	// age, and a sequence start in the middle of a stream.
	task automatic test_deque_order();
		write_window(4);
		send_sample(10, 1'b1);
		send_sample(20, 1'b0);
		send_sample(20, 1'b0);
		send_sample(5, 1'b0);
		send_sample(3, 1'b0);
		send_sample(1, 1'b0);
		send_sample(-1, 1'b0);
		send_sample(-7, 1'b1);
		send_sample(SAMPLE_MAX, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
	endtask

	// Out-of-range window sizes; the shrink to zero lands mid-sequence.
	task automatic test_window_clamp();
		write_window('0);
		send_sample(-2, 1'b0);
		send_sample(7, 1'b0);
		write_window('1);
		send_sample(SAMPLE_MAX, 1'b1);
		send_sample(3, 1'b0);
		send_sample(SAMPLE_MIN, 1'b0);
	endtask

	// Random sequences over a spread of window sizes, extremes first. Phases
	// do not always open with a start, so each size change also hits a live
	// deque. One phase in four runs with no gaps; one pauses the input until
	// all results are back.
	task automatic test_random_streams();
		logic [WIN_WIDTH-1:0] w;
		int span;
		int sent;
		int len;
		bit paused;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: w = WIN_WIDTH'(1);
				1: w = WIN_WIDTH'(MAX_W);
				2: w = '0;
				3: w = '1;
				4: w = WIN_WIDTH'(MAX_W + 1);
				5: w = WIN_WIDTH'(2);
				default: w = WIN_WIDTH'($urandom_range(1, MAX_W));
			endcase
			write_window(w);
			steady = (phase % 4 == 3);
			span = window_span(w);
			sent = 0;
			paused = 1'b0;
			while (sent < PHASE_ITEMS) begin
				len = $urandom_range(1, 2 * span + 8);
				if (len > PHASE_ITEMS - sent)
					len = PHASE_ITEMS - sent;
				send_run(len, $urandom_range(0, 4) != 0);
				sent += len;
				if (phase == 6 && !paused && sent >= PHASE_ITEMS / 2) begin
					wait_results();
					paused = 1'b1;
				end
			end
		end
		steady = 1'b0;
	endtask

	// Result side stalls: idle most cycles, short bursts, the odd long hold.
	always @(posedge clk) begin : result_stall
		int r;
		if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
			out_stall <= 1'b1;
		end else if (steady) begin
			out_stall <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				out_stall <= 1'b0;
			end else if (r < 93) begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(15, 60);
			end
		end
	end

	// Compare every result transfer with the oldest prediction.
	always @(posedge clk) begin : result_check
		logic signed [DW-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expect_wr == expect_rd) begin
				fail_count++;
				$error("window_max: expected no result, actual %0d", window_max);
			end else begin
				want = expected_max[expect_rd % EXPECT_DEPTH];
				expect_rd++;
				if (window_max !== want) begin
					fail_count++;
					$error("window_max: expected %0d, actual %0d", want, window_max);
				end
			end
		end
	end

	// Hard stop if the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		// release reset away from the active edge
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_deque_order();
		test_window_clamp();
		test_random_streams();
		settle();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
